// File: rtl/fqrk_pkg.sv
package fqrk_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int HND_BITS    = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W     = ID_BITS + HND_BITS;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_KILL    = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

endpackage

// File: rtl/fqrk_ram.sv
module fqrk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/fifo_queue_with_remove_by_key.sv
// ordered queue of process entries (id and handle) with removal by id.
// input channel: in_valid / in_stall carry operation, proc_id and entry_handle;
// one transaction is taken at a time, in_stall stays high until its result
// has been placed in the output register.
// output channel: out_valid / out_stall carry status, out_id, out_handle and
// occupancy; exactly one result transaction per input transaction, in order.
// enqueue or an unused operation code goes straight to the result; dequeue
// and kill scan from the head, dequeue taking the first entry read and kill
// the first entry whose id matches; the scan reads one entry a cycle, then
// the entries behind the match are moved down one slot a cycle.
// the next input transaction is taken no sooner than the cycle after the
// result is loaded, so only one transaction at a time holds the block.
// the entries sit in one ram with a registered read port.
// reset clears the entry count and all handshake state; ram contents are
// left as they are and never read before being written.
// while the receiver stalls, the result is held and the next input
// transaction is worked on until it too has a result ready.
module fifo_queue_with_remove_by_key (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] proc_id,
	input  logic [15:0] entry_handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [15:0] out_handle,
	output logic [4:0]  occupancy
);

	fqrk_pkg::state_t state_q, state_d;

	logic [fqrk_pkg::CNT_W-1:0]   count_q;
	logic [fqrk_pkg::CNT_W-1:0]   idx_q;
	logic                         rd_vld_s1;
	logic [fqrk_pkg::PTR_W-1:0]   rd_idx_s1;
	logic [fqrk_pkg::ID_BITS-1:0] key_q;
	logic                         deq_q;
	logic [1:0]                   res_status_q;
	logic [15:0]                  res_id_q;
	logic [15:0]                  res_hnd_q;

	logic                           ram_we;
	logic [fqrk_pkg::PTR_W-1:0]     ram_waddr;
	logic [fqrk_pkg::ENTRY_W-1:0]   ram_wdata;
	logic                           ram_re;
	logic [fqrk_pkg::PTR_W-1:0]     ram_raddr;
	logic [fqrk_pkg::ENTRY_W-1:0]   ram_rdata;
	logic [fqrk_pkg::ID_BITS-1:0]   rd_id;
	logic [fqrk_pkg::HND_BITS-1:0]  rd_hnd;

	logic accept;
	logic is_full;
	logic issue;
	logic hit;
	logic load_out;

	assign rd_id   = ram_rdata[fqrk_pkg::ENTRY_W-1 -: fqrk_pkg::ID_BITS];
	assign rd_hnd  = ram_rdata[fqrk_pkg::HND_BITS-1:0];
	assign is_full = (count_q == fqrk_pkg::CNT_W'(fqrk_pkg::QUEUE_DEPTH));

	fqrk_ram #(
		.WIDTH(fqrk_pkg::ENTRY_W),
		.DEPTH(fqrk_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// outputs of the state machine
	always_comb begin
		in_stall  = 1'b1;
		accept    = 1'b0;
		issue     = 1'b0;
		hit       = 1'b0;
		load_out  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[fqrk_pkg::PTR_W-1:0];
		ram_wdata = {(fqrk_pkg::ID_BITS)'(proc_id), (fqrk_pkg::HND_BITS)'(entry_handle)};
		ram_re    = 1'b0;
		ram_raddr = idx_q[fqrk_pkg::PTR_W-1:0];
		case (state_q)
			fqrk_pkg::S_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				ram_we   = in_valid && (operation == fqrk_pkg::OP_ENQUEUE) && !is_full;
			end
			fqrk_pkg::S_SCAN: begin
				hit    = rd_vld_s1 && (deq_q || (rd_id == key_q));
				issue  = !hit && (idx_q < count_q);
				ram_re = issue;
			end
			fqrk_pkg::S_SHIFT: begin
				issue     = (idx_q < count_q);
				ram_re    = issue;
				ram_we    = rd_vld_s1;
				ram_waddr = rd_idx_s1 - fqrk_pkg::PTR_W'(1);
				ram_wdata = ram_rdata;
			end
			fqrk_pkg::S_FINISH: begin
				load_out = !out_valid || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fqrk_pkg::S_IDLE: begin
				if (accept) begin
					if ((operation == fqrk_pkg::OP_DEQUEUE) || (operation == fqrk_pkg::OP_KILL)) begin
						state_d = fqrk_pkg::S_SCAN;
					end else begin
						state_d = fqrk_pkg::S_FINISH;
					end
				end
			end
			fqrk_pkg::S_SCAN: begin
				if (hit) begin
					state_d = fqrk_pkg::S_SHIFT;
				end else if (!issue && !rd_vld_s1) begin
					state_d = fqrk_pkg::S_FINISH;
				end
			end
			fqrk_pkg::S_SHIFT: begin
				if (!issue && !rd_vld_s1) begin
					state_d = fqrk_pkg::S_FINISH;
				end
			end
			fqrk_pkg::S_FINISH: begin
				if (load_out) begin
					state_d = fqrk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fqrk_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fqrk_pkg::S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			if (accept) begin
				idx_q <= '0;
				if ((operation == fqrk_pkg::OP_ENQUEUE) && !is_full) begin
					count_q <= count_q + fqrk_pkg::CNT_W'(1);
				end
			end else if (hit) begin
				idx_q <= fqrk_pkg::CNT_W'(rd_idx_s1) + fqrk_pkg::CNT_W'(1);
			end else if (issue) begin
				idx_q <= idx_q + fqrk_pkg::CNT_W'(1);
			end
			// the removed entry leaves once the shift has drained
			if ((state_q == fqrk_pkg::S_SHIFT) && (state_d == fqrk_pkg::S_FINISH)) begin
				count_q <= count_q - fqrk_pkg::CNT_W'(1);
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[fqrk_pkg::PTR_W-1:0];
		if (accept) begin
			key_q     <= (fqrk_pkg::ID_BITS)'(proc_id);
			deq_q     <= (operation == fqrk_pkg::OP_DEQUEUE);
			res_id_q  <= '0;
			res_hnd_q <= '0;
			if (operation == fqrk_pkg::OP_ENQUEUE) begin
				res_status_q <= is_full ? fqrk_pkg::STAT_FULL : fqrk_pkg::STAT_OK;
			end else if ((operation == fqrk_pkg::OP_DEQUEUE) ||
			             (operation == fqrk_pkg::OP_KILL)) begin
				res_status_q <= fqrk_pkg::STAT_NONE;
			end else begin
				res_status_q <= fqrk_pkg::STAT_OK;
			end
		end else if (hit) begin
			res_status_q <= fqrk_pkg::STAT_OK;
			res_id_q     <= 16'(rd_id);
			res_hnd_q    <= 16'(rd_hnd);
		end
		if (load_out) begin
			status     <= res_status_q;
			out_id     <= res_id_q;
			out_handle <= res_hnd_q;
			occupancy  <= 5'(count_q);
		end
	end

endmodule
